### hw/rtl/convolution_3x3_sharpen_emboss_defines.svh
// Assertion macros used by the checker file of the convolution block.
`ifndef CONVOLUTION_3X3_SHARPEN_EMBOSS_DEFINES_SVH
`define CONVOLUTION_3X3_SHARPEN_EMBOSS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CV3_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cv3 same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CV3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cv3 next-cycle check failed");

`endif

### hw/rtl/cv3_pkg.sv
package cv3_pkg;

  // Line length and the widths that follow from it.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

  // Configuration register widths.
  localparam int CFG_MODE_W   = 2;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int WCMP_W       = (CNT_W > CFG_WIDTH_W) ? CNT_W : CFG_WIDTH_W;
  localparam int ROW_W        = 16;

  // Arithmetic widths of the kernel datapath.
  localparam int COEF_W   = 4;
  localparam int TERM_W   = 13;
  localparam int ROWSUM_W = 15;
  localparam int SUM_W    = 16;

  // Result queue sizing.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

  // Kernel modes.
  localparam logic [CFG_MODE_W-1:0] MODE_PASS    = 2'd0;
  localparam logic [CFG_MODE_W-1:0] MODE_SHARPEN = 2'd1;
  localparam logic [CFG_MODE_W-1:0] MODE_EMBOSS  = 2'd2;

  // Request types.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Kernel taps in window order, oldest column first, top row first.
  localparam coef_t SHARPEN_TAPS [9] = '{
    4'sd0, -4'sd1, 4'sd0,
    -4'sd1, 4'sd5, -4'sd1,
    4'sd0, -4'sd1, 4'sd0
  };
  localparam coef_t EMBOSS_TAPS [9] = '{
    -4'sd2, -4'sd1, 4'sd0,
    -4'sd1, 4'sd1, 4'sd1,
    4'sd0, 4'sd1, 4'sd2
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One line buffer word: the older row and the newer row at one column.
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green;
    logic signed [TERM_W-1:0] blue;
  } term_t;

  typedef struct packed {
    logic signed [ROWSUM_W-1:0] red;
    logic signed [ROWSUM_W-1:0] green;
    logic signed [ROWSUM_W-1:0] blue;
  } rsum_t;

  // Per-result control carried down the pipeline.
  typedef struct packed {
    logic apply;
    logic last;
  } ctl_t;

  typedef struct packed {
    pix_t pix;
    logic end_of_image;
  } res_t;

  // Clamp a kernel sum to the pixel range.
  function automatic logic [7:0] clamp_pix(input logic signed [SUM_W-1:0] acc);
    logic [7:0] res;
    if (acc < 0) begin
      res = '0;
    end else if (acc > $signed(SUM_W'(PIX_MAX))) begin
      res = PIX_MAX;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/cv3_win_cell.sv
module cv3_win_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  cv3_pkg::pix_t  din,
  input  cv3_pkg::coef_t coef,
  output cv3_pkg::pix_t  dout,
  output cv3_pkg::term_t term
);

  cv3_pkg::pix_t pix_r;

  // Window slot: takes the pixel on its input (a neighbor's, or the new column's) on every shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift_en) begin
      pix_r <= din;
    end
  end

  assign dout = pix_r;

  // Weighted contribution of this slot, one product with a small coefficient per channel.
  assign term.red   = cv3_pkg::TERM_W'($signed({1'b0, pix_r.red}))
                    * cv3_pkg::TERM_W'(coef);
  assign term.green = cv3_pkg::TERM_W'($signed({1'b0, pix_r.green}))
                    * cv3_pkg::TERM_W'(coef);
  assign term.blue  = cv3_pkg::TERM_W'($signed({1'b0, pix_r.blue}))
                    * cv3_pkg::TERM_W'(coef);

endmodule

### hw/rtl/cv3_line_buf.sv
module cv3_line_buf (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [cv3_pkg::COL_W-1:0] rd_col,
  input  logic                      wr_en,
  input  logic [cv3_pkg::COL_W-1:0] wr_col,
  input  cv3_pkg::line_t            wr_data,
  output cv3_pkg::line_t            rd_data
);

  cv3_pkg::line_t mem [cv3_pkg::MAX_WIDTH];
  cv3_pkg::line_t rd_q_r;
  cv3_pkg::line_t fwd_data_r;
  logic           fwd_hit_r;

  // One read and one write per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_col];
    end
    if (wr_en) begin
      mem[wr_col] <= wr_data;
    end
    fwd_data_r <= wr_data;
  end

  // A read that meets a write to the same column in the same cycle takes the new word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (wr_col == rd_col);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

### hw/rtl/cv3_out_fifo.sv
module cv3_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cv3_pkg::res_t push_data,
  input  logic          pop,
  output logic          head_valid,
  output cv3_pkg::res_t head_data
);

  cv3_pkg::res_t                    fifo_mem_r [cv3_pkg::FIFO_DEPTH];
  logic [cv3_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [cv3_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [cv3_pkg::CRED_W-1:0]       cnt_r;
  logic [cv3_pkg::FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [cv3_pkg::FIFO_PTR_W-1:0]   rd_ptr_nxt;

  // Pointer wrap for any depth.
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == cv3_pkg::FIFO_PTR_W'(cv3_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_r + cv3_pkg::FIFO_PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == cv3_pkg::FIFO_PTR_W'(cv3_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_r + cv3_pkg::FIFO_PTR_W'(1);
  end

  // Result storage; the credit count upstream keeps it from overflowing.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_r + cv3_pkg::CRED_W'(push) - cv3_pkg::CRED_W'(pop);
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = fifo_mem_r[rd_ptr_r];

endmodule

### hw/rtl/convolution_3x3_sharpen_emboss.sv
// 3x3 sharpen / emboss filter on a raster stream of BGR pixels.
// Input channel (in_*): one pixel per transfer in raster order, or a flush
// request once the whole image has been sent; each flush pushes out one of the
// trailing results. A flush sent while pixels are still expected is dropped.
// Output channel (out_*): one filtered pixel per result, out_end_of_image set on
// the last pixel of the image, after which the position counters restart.
// Output pixel k is produced by input transfer k + width + 1. The result shows
// on out_valid after that transfer passes the line buffer read, window shift,
// row sums, and final sum and clamp into the result queue.
// Throughput is one transfer per clock while in_ready is high, set by the line
// buffer's one read and one write and the one-column window shift per item.
// An eight-entry result queue with credit counting parts the two sides: input
// keeps flowing while results wait, and in_ready drops only when eight results
// are in flight or waiting. A stalled receiver sees out_valid and data held.
// Configuration (cfg_*) is written with cfg_wr_en, one register per cycle, and
// only while the block is idle, a user's rule the block does not enforce. Reset
// (rst_n low, synchronous) clears counters, window and queue, loads passthrough,
// width 2048, height 1; the line buffer is not cleared and needs no clearing pass.
module convolution_3x3_sharpen_emboss (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [7:0]                      in_pix_blue,
  input  logic [7:0]                      in_pix_green,
  input  logic [7:0]                      in_pix_red,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_red,
  output logic                            out_end_of_image,
  input  logic                            cfg_wr_en,
  input  logic [cv3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

  // Configuration registers.
  logic [cv3_pkg::CFG_MODE_W-1:0]   mode_r;
  logic [cv3_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [cv3_pkg::CFG_HEIGHT_W-1:0] height_r;

  // Position counters.
  logic [cv3_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic [cv3_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic [cv3_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [cv3_pkg::ROW_W-1:0] out_row_r, out_row_nxt;

  // Decoded sizes and item classification.
  logic [cv3_pkg::WCMP_W-1:0] w_ext, w_sat;
  logic [cv3_pkg::CNT_W-1:0]  w_eff;
  logic [cv3_pkg::ROW_W-1:0]  h_eff;
  logic [cv3_pkg::COL_W-1:0]  col_eff, out_col_eff;
  logic [cv3_pkg::ROW_W:0]    orow_inc;
  logic                       draining, take, ignored, step, emit;
  logic                       col_last, ocol_last, orow_last;
  cv3_pkg::ctl_t              ctl;
  cv3_pkg::pix_t              pix_in;

  // Pipeline registers.
  logic                      s1_valid_r, s1_emit_r;
  cv3_pkg::ctl_t             s1_ctl_r;
  cv3_pkg::pix_t             s1_pix_r;
  logic [cv3_pkg::COL_W-1:0] s1_col_r;
  logic                      s2_valid_r;
  cv3_pkg::ctl_t             s2_ctl_r;
  logic                      s3_valid_r;
  cv3_pkg::ctl_t             s3_ctl_r;
  cv3_pkg::pix_t             s3_center_r;
  cv3_pkg::rsum_t            s3_rsum_r [3];
  cv3_pkg::rsum_t            rsum [3];

  // Line buffer and window.
  cv3_pkg::line_t  lb_rd;
  cv3_pkg::line_t  lb_wr;
  cv3_pkg::pix_t   feed     [3];
  cv3_pkg::pix_t   cell_din [9];
  cv3_pkg::pix_t   cell_dout[9];
  cv3_pkg::term_t  cell_term[9];
  cv3_pkg::coef_t  cell_coef[9];

  // Result assembly and flow control.
  logic signed [cv3_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue;
  cv3_pkg::res_t                    res;
  logic                             pop;
  logic [cv3_pkg::CRED_W-1:0]       credit_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cv3_pkg::MODE_PASS;
      width_r  <= cv3_pkg::CFG_WIDTH_W'(2048);
      height_r <= cv3_pkg::CFG_HEIGHT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cv3_pkg::CFG_KERNEL_MODE:  mode_r   <= cfg_wr_data[cv3_pkg::CFG_MODE_W-1:0];
        cv3_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wr_data[cv3_pkg::CFG_WIDTH_W-1:0];
        cv3_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wr_data[cv3_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size: zero counts as one, width saturates at the line length.
  always_comb begin
    w_ext = cv3_pkg::WCMP_W'(width_r);
    if (w_ext == '0) begin
      w_sat = cv3_pkg::WCMP_W'(1);
    end else if (w_ext > cv3_pkg::WCMP_W'(cv3_pkg::MAX_WIDTH)) begin
      w_sat = cv3_pkg::WCMP_W'(cv3_pkg::MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    w_eff = cv3_pkg::CNT_W'(w_sat);
    h_eff = (height_r == '0) ? cv3_pkg::ROW_W'(1) : height_r;
  end

  // Column counters beyond a shrunk width are pulled back to the last column.
  always_comb begin
    col_eff     = (cv3_pkg::CNT_W'(in_col_r) >= w_eff) ?
                  cv3_pkg::COL_W'(w_eff - cv3_pkg::CNT_W'(1)) : in_col_r;
    out_col_eff = (cv3_pkg::CNT_W'(out_col_r) >= w_eff) ?
                  cv3_pkg::COL_W'(w_eff - cv3_pkg::CNT_W'(1)) : out_col_r;
  end

  // Classify the item at the input and decide what result it releases.
  always_comb begin
    draining  = (in_row_r >= h_eff);
    take      = in_valid && in_ready;
    ignored   = !draining && (in_req_type == cv3_pkg::REQ_FLUSH);
    step      = take && !ignored;
    emit      = (in_row_r >= cv3_pkg::ROW_W'(2)) ||
                ((in_row_r == cv3_pkg::ROW_W'(1)) && (col_eff != '0));
    col_last  = (cv3_pkg::CNT_W'(col_eff) + cv3_pkg::CNT_W'(1)) >= w_eff;
    ocol_last = (cv3_pkg::CNT_W'(out_col_eff) + cv3_pkg::CNT_W'(1)) >= w_eff;
    orow_inc  = {1'b0, out_row_r} + (cv3_pkg::ROW_W + 1)'(1);
    orow_last = orow_inc >= {1'b0, h_eff};
    ctl.last  = orow_last && ocol_last;
    ctl.apply = ((mode_r == cv3_pkg::MODE_SHARPEN) || (mode_r == cv3_pkg::MODE_EMBOSS)) &&
                (out_row_r != '0) && !orow_last && (out_col_eff != '0) && !ocol_last;
    if (draining) begin
      pix_in = '0;
    end else begin
      pix_in.red   = in_pix_red;
      pix_in.green = in_pix_green;
      pix_in.blue  = in_pix_blue;
    end
  end

  // Next positions of both counter pairs.
  always_comb begin
    in_col_nxt  = col_eff;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_eff;
    out_row_nxt = out_row_r;
    if (!ignored) begin
      if (col_last) begin
        in_col_nxt = '0;
        if (in_row_r != {cv3_pkg::ROW_W{1'b1}}) begin
          in_row_nxt = in_row_r + cv3_pkg::ROW_W'(1);
        end
      end else begin
        in_col_nxt = col_eff + cv3_pkg::COL_W'(1);
      end
      if (emit) begin
        if (ctl.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = orow_inc[cv3_pkg::ROW_W-1:0];
        end else begin
          out_col_nxt = out_col_eff + cv3_pkg::COL_W'(1);
        end
      end
    end
  end

  // Position counters advance on every transfer but a dropped flush.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (take) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // First stage: item waits for its line buffer read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= step;
    end
    s1_emit_r <= emit;
    s1_ctl_r  <= ctl;
    s1_pix_r  <= pix_in;
    s1_col_r  <= col_eff;
  end

  // Line buffer: the newer row moves to the older half, the new pixel takes its place.
  assign lb_wr.top = lb_rd.mid;
  assign lb_wr.mid = s1_pix_r;

  cv3_line_buf u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (step),
    .rd_col  (col_eff),
    .wr_en   (s1_valid_r),
    .wr_col  (s1_col_r),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  // New column entering the window, top row first.
  assign feed[0] = lb_rd.top;
  assign feed[1] = lb_rd.mid;
  assign feed[2] = s1_pix_r;

  // Window cells: each row shifts toward the oldest column.
  for (genvar i = 0; i < 9; i++) begin : g_cell
    if ((i % 3) == 2) begin : g_edge
      assign cell_din[i] = feed[i / 3];
    end else begin : g_inner
      assign cell_din[i] = cell_dout[i + 1];
    end

    assign cell_coef[i] = (mode_r == cv3_pkg::MODE_EMBOSS) ?
                          cv3_pkg::EMBOSS_TAPS[i] : cv3_pkg::SHARPEN_TAPS[i];

    cv3_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_valid_r),
      .din      (cell_din[i]),
      .coef     (cell_coef[i]),
      .dout     (cell_dout[i]),
      .term     (cell_term[i])
    );
  end

  // Row sums of the weighted window.
  for (genvar r = 0; r < 3; r++) begin : g_row
    assign rsum[r].red   = cv3_pkg::ROWSUM_W'(cell_term[3*r].red)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+1].red)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+2].red);
    assign rsum[r].green = cv3_pkg::ROWSUM_W'(cell_term[3*r].green)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+1].green)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+2].green);
    assign rsum[r].blue  = cv3_pkg::ROWSUM_W'(cell_term[3*r].blue)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+1].blue)
                         + cv3_pkg::ROWSUM_W'(cell_term[3*r+2].blue);
  end

  // Second and third stages: window settled, then row sums registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
      s3_valid_r <= s2_valid_r;
    end
    s2_ctl_r    <= s1_ctl_r;
    s3_ctl_r    <= s2_ctl_r;
    s3_center_r <= cell_dout[4];
    s3_rsum_r   <= rsum;
  end

  // Final sum and clamp, or the center pixel on borders and in passthrough.
  always_comb begin
    sum_red   = cv3_pkg::SUM_W'(s3_rsum_r[0].red) + cv3_pkg::SUM_W'(s3_rsum_r[1].red)
              + cv3_pkg::SUM_W'(s3_rsum_r[2].red);
    sum_green = cv3_pkg::SUM_W'(s3_rsum_r[0].green) + cv3_pkg::SUM_W'(s3_rsum_r[1].green)
              + cv3_pkg::SUM_W'(s3_rsum_r[2].green);
    sum_blue  = cv3_pkg::SUM_W'(s3_rsum_r[0].blue) + cv3_pkg::SUM_W'(s3_rsum_r[1].blue)
              + cv3_pkg::SUM_W'(s3_rsum_r[2].blue);
    if (s3_ctl_r.apply) begin
      res.pix.red   = cv3_pkg::clamp_pix(sum_red);
      res.pix.green = cv3_pkg::clamp_pix(sum_green);
      res.pix.blue  = cv3_pkg::clamp_pix(sum_blue);
    end else begin
      res.pix = s3_center_r;
    end
    res.end_of_image = s3_ctl_r.last;
  end

  cv3_pkg::res_t head;

  cv3_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s3_valid_r),
    .push_data  (res),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign pop              = out_valid && out_ready;
  assign out_red          = head.pix.red;
  assign out_green        = head.pix.green;
  assign out_blue         = head.pix.blue;
  assign out_end_of_image = head.end_of_image;

  // Credits: results in flight plus results queued never exceed the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + cv3_pkg::CRED_W'(step && emit) - cv3_pkg::CRED_W'(pop);
    end
  end

  assign in_ready = (credit_r < cv3_pkg::CRED_W'(cv3_pkg::FIFO_DEPTH));

endmodule

### hw/rtl/cv3_checker.sv
`include "convolution_3x3_sharpen_emboss_defines.svh"

module cv3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red,
  input logic       out_end_of_image
);

  // The whole offered result as one word.
  logic [24:0] out_word;

  assign out_word = {out_end_of_image, out_red, out_green, out_blue};

  // A stalled result stays offered with the same contents.
  `CV3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // Leaving reset, the result queue is empty and the input is open.
  `CV3_ASSERT_IMPL(a_reset_empty, $rose(rst_n), !out_valid && in_ready)

  // With no result queued, only results in the pipeline stages are in flight, fewer than the queue depth.
  `CV3_ASSERT_IMPL(a_empty_open, !out_valid, in_ready)

  // A result is never offered in the cycle right after reset releases.
  `CV3_ASSERT_IMPL(a_no_early_out, $past(!rst_n), !out_valid)

endmodule

bind convolution_3x3_sharpen_emboss cv3_checker u_cv3_checker (.*);

### tb/sv/convolution_3x3_sharpen_emboss_tb.sv
module convolution_3x3_sharpen_emboss_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cv3_pkg::*;

  localparam int IDLE_PCT      = 21;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Codes outside the defined set: a spare mode that acts as passthrough and an unused register index.
  localparam logic [CFG_MODE_W-1:0]  MODE_SPARE       = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // One pending input transfer.
  typedef struct packed {
    logic req;
    pix_t px;
  } pixel_xfer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_req_type = REQ_PIXEL;
  logic [7:0]             in_pix_blue = '0;
  logic [7:0]             in_pix_green = '0;
  logic [7:0]             in_pix_red = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_blue;
  logic [7:0]             out_green;
  logic [7:0]             out_red;
  logic                   out_end_of_image;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

  pixel_xfer_t pixel_queue[$];
  res_t        filtered_expect[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          random_items = 0;
  int unsigned cycle_count = 0;
  bit          calm_stretch = 1'b0;
  int          hold_requests = 0;
  int          hold_grants = 0;
  int          rx_hold_left = 0;

  // Shadow copy of the configuration registers.
  logic [CFG_MODE_W-1:0]   mode_sh = MODE_PASS;
  logic [CFG_WIDTH_W-1:0]  width_sh = 12'd2048;
  logic [CFG_HEIGHT_W-1:0] height_sh = 16'd1;

  // Predictor state: line memory, neighborhood window and stream positions.
  pix_t             row_mem [2*MAX_WIDTH] = '{default: '0};
  pix_t             nbhd [9] = '{default: '0};
  logic [COL_W-1:0] feed_col = '0;
  logic [ROW_W-1:0] feed_row = '0;
  logic [COL_W-1:0] emit_col = '0;
  logic [ROW_W-1:0] emit_row = '0;

  convolution_3x3_sharpen_emboss u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pix_blue      (in_pix_blue),
    .in_pix_green     (in_pix_green),
    .in_pix_red       (in_pix_red),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_end_of_image (out_end_of_image),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("convolution_3x3_sharpen_emboss verification failed");
    $finish;
  end

  function automatic int eff_width();
    if (width_sh == 0) return 1;
    if (width_sh > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_sh);
  endfunction

  function automatic int eff_height();
    if (height_sh == 0) return 1;
    return int'(height_sh);
  endfunction

  function automatic int kernel_tap(input logic [CFG_MODE_W-1:0] mode, input int t);
    int sharpen_k [9];
    int emboss_k [9];
    sharpen_k = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
    emboss_k  = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
    return (mode == MODE_EMBOSS) ? emboss_k[t] : sharpen_k[t];
  endfunction

  function automatic logic [7:0] sat_byte(input int acc);
    if (acc < 0) return 8'h00;
    if (acc > 255) return 8'hFF;
    return 8'(acc);
  endfunction

  // Advances the predictor by one accepted transfer; returns 1 when the
  // transfer pushes out a filtered pixel.
  function automatic bit filter_step(input logic req, input pix_t px, output res_t res);
    int   w;
    int   h;
    int   col;
    int   r;
    int   t;
    int   b_acc;
    int   g_acc;
    int   r_acc;
    bit   emit;
    bit   last;
    pix_t fresh;
    pix_t upper;
    pix_t middle;
    w = eff_width();
    h = eff_height();
    res = '0;
    if (feed_col >= w) feed_col = COL_W'(w - 1);
    if (emit_col >= w) emit_col = COL_W'(w - 1);
    // A flush while pixels of the image are still due is dropped.
    if (feed_row < h && req == REQ_FLUSH) return 1'b0;
    // Once the image is in, every transfer feeds a blank pixel.
    fresh = (feed_row >= h) ? pix_t'('0) : px;
    col = feed_col;
    middle = row_mem[col];
    upper = row_mem[MAX_WIDTH + col];
    row_mem[MAX_WIDTH + col] = middle;
    row_mem[col] = fresh;
    for (r = 0; r < 3; r++) begin
      nbhd[3*r] = nbhd[3*r + 1];
      nbhd[3*r + 1] = nbhd[3*r + 2];
    end
    nbhd[2] = upper;
    nbhd[5] = middle;
    nbhd[8] = fresh;
    emit = (feed_row >= 2) || (feed_row == 1 && col >= 1);
    if (col + 1 >= w) begin
      feed_col = '0;
      if (feed_row != 16'hFFFF) feed_row = feed_row + 1'b1;
    end else begin
      feed_col = COL_W'(col + 1);
    end
    if (!emit) return 1'b0;

    // Interior pixels get the kernel; borders and passthrough keep the center.
    res.pix = nbhd[4];
    if ((mode_sh == MODE_SHARPEN || mode_sh == MODE_EMBOSS) && emit_row >= 1 &&
        emit_row + 1 < h && emit_col >= 1 && emit_col + 1 < w) begin
      b_acc = 0;
      g_acc = 0;
      r_acc = 0;
      for (t = 0; t < 9; t++) begin
        b_acc += int'(nbhd[t].blue) * kernel_tap(mode_sh, t);
        g_acc += int'(nbhd[t].green) * kernel_tap(mode_sh, t);
        r_acc += int'(nbhd[t].red) * kernel_tap(mode_sh, t);
      end
      res.pix.blue = sat_byte(b_acc);
      res.pix.green = sat_byte(g_acc);
      res.pix.red = sat_byte(r_acc);
    end

    last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
    res.end_of_image = last;
    if (last) begin
      feed_col = '0;
      feed_row = '0;
      emit_col = '0;
      emit_row = '0;
    end else if (emit_col + 1 >= w) begin
      emit_col = '0;
      emit_row = emit_row + 1'b1;
    end else begin
      emit_col = emit_col + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Input side: predict on each transfer, then present the next item or idle.
  always @(posedge clk) begin
    pixel_xfer_t nxt;
    res_t        res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (filter_step(in_req_type, '{red: in_pix_red, green: in_pix_green,
                                        blue: in_pix_blue}, res)) begin
          filtered_expect.push_back(res);
        end
      end
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() != 0 &&
            (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_req_type <= nxt.req;
          in_pix_blue <= nxt.px.blue;
          in_pix_green <= nxt.px.green;
          in_pix_red <= nxt.px.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_grants != hold_requests) begin
      rx_hold_left <= HOLD_CYCLES;
      hold_grants <= hold_grants + 1;
    end
  end

  // Output side: check each transfer against the oldest expected pixel.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = filtered_expect.pop_front();
          if (out_blue !== want.pix.blue)
            report_mismatch($sformatf("result %0d blue got %0d expected %0d",
                                      results_seen, out_blue, want.pix.blue));
          if (out_green !== want.pix.green)
            report_mismatch($sformatf("result %0d green got %0d expected %0d",
                                      results_seen, out_green, want.pix.green));
          if (out_red !== want.pix.red)
            report_mismatch($sformatf("result %0d red got %0d expected %0d",
                                      results_seen, out_red, want.pix.red));
          if (out_end_of_image !== want.end_of_image)
            report_mismatch($sformatf("result %0d end_of_image got %0b expected %0b",
                                      results_seen, out_end_of_image, want.end_of_image));
        end
        results_seen <= results_seen + 1;
      end
      out_ready <= (rx_hold_left == 0) && (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_KERNEL_MODE:  mode_sh = data[CFG_MODE_W-1:0];
      CFG_IMAGE_WIDTH:  width_sh = data[CFG_WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: height_sh = data[CFG_HEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t px;
    px.blue = rand_byte();
    px.green = rand_byte();
    px.red = rand_byte();
    return px;
  endfunction

  task automatic queue_item(input logic req, input pix_t px);
    pixel_xfer_t item;
    item.req = req;
    item.px = px;
    pixel_queue.push_back(item);
  endtask

  // Queues an image: pixels with a few stray flushes, then the drain items.
  task automatic send_image(input int npix, input int ndrain);
    int k;
    for (k = 0; k < npix; k++) begin
      if ($urandom_range(0, 99) < 6) queue_item(REQ_FLUSH, rand_pixel());
      queue_item(REQ_PIXEL, rand_pixel());
    end
    for (k = 0; k < ndrain; k++)
      queue_item(($urandom_range(0, 99) < 15) ? REQ_PIXEL : REQ_FLUSH, rand_pixel());
    random_items += npix + ndrain;
  endtask

  // Feeds one item at a time until the predictor is back at an image start.
  task automatic close_image();
    while (!(feed_col == 0 && feed_row == 0 && emit_col == 0 && emit_row == 0)) begin
      if (feed_row >= eff_height())
        queue_item(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_FLUSH, rand_pixel());
      else
        queue_item(REQ_PIXEL, rand_pixel());
      random_items++;
      do @(negedge clk); while (pixel_queue.size() != 0 || in_valid);
    end
  endtask

  // Sender pause: everything sent, every result in, pipeline quiet.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || filtered_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int                    x;
    int                    y;
    int                    w;
    int                    h;
    int                    roll;
    logic [CFG_MODE_W-1:0] m;
    pix_t                  px;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // Directed: 4x3 sharpen on a checkerboard drives both clamps; a stray
    // flush mid-image and a pixel during the drain are both covered.
    write_reg(CFG_KERNEL_MODE, 16'(MODE_SHARPEN));
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 4; x++) begin
        px.blue = ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
        px.green = ~px.blue;
        px.red = rand_byte();
        queue_item(REQ_PIXEL, px);
        if (x == 1 && y == 1) queue_item(REQ_FLUSH, '1);
      end
    end
    queue_item(REQ_PIXEL, '1);
    repeat (4) queue_item(REQ_FLUSH, '0);
    wait_drained();

    // Width above the maximum saturates; the first row is cut short and the
    // width shrunk, so the column counter is pulled back into the new row.
    write_reg(CFG_KERNEL_MODE, 16'(MODE_EMBOSS));
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_image(40, 0);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 16'd6);
    close_image();
    wait_drained();

    // The receiver holds off while a whole image is offered, so the block
    // fills up and stalls its input.
    write_reg(CFG_KERNEL_MODE, 16'(MODE_SHARPEN));
    write_reg(CFG_IMAGE_WIDTH, 16'd16);
    write_reg(CFG_IMAGE_HEIGHT, 16'd8);
    hold_requests = hold_requests + 1;
    send_image(16 * 8, 17);
    wait_drained();

    // A long stretch with no idling on either side.
    calm_stretch = 1'b1;
    write_reg(CFG_KERNEL_MODE, 16'(MODE_EMBOSS));
    write_reg(CFG_IMAGE_WIDTH, 16'd20);
    write_reg(CFG_IMAGE_HEIGHT, 16'd6);
    send_image(20 * 6, 21);
    wait_drained();
    calm_stretch = 1'b0;

    // Random images of mostly small sizes; some are cut short and reshaped.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      m = (roll < 15) ? MODE_PASS : (roll < 55) ? MODE_SHARPEN :
          (roll < 95) ? MODE_EMBOSS : MODE_SPARE;
      write_reg(CFG_KERNEL_MODE, {14'($urandom), m});
      roll = $urandom_range(0, 99);
      w = (roll < 5) ? 0 : (roll < 15) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
      roll = $urandom_range(0, 99);
      h = (roll < 8) ? 0 : (roll < 18) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      write_reg(CFG_IMAGE_HEIGHT, 16'(h));
      if ($urandom_range(0, 19) == 0) write_reg(CFG_UNUSED_INDEX, 16'($urandom));
      w = eff_width();
      h = eff_height();
      if ($urandom_range(0, 99) < 20) begin
        send_image($urandom_range(1, w * h), 0);
        wait_drained();
        case ($urandom_range(0, 2))
          0:       write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(1, w + 3)));
          1:       write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(1, h + 2)));
          default: write_reg(CFG_KERNEL_MODE, 16'($urandom_range(0, 3)));
        endcase
        close_image();
      end else begin
        send_image(w * h, w + 1);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("convolution_3x3_sharpen_emboss verification clean");
    end else begin
      $display("convolution_3x3_sharpen_emboss verification failed");
    end
    $finish;
  end

endmodule
